@@ hdl/spq_pkg.sv @@
// Shared types and constants for the scale pitch quantizer.
// Holds the pipeline stage payload structs, opcode and register index codes.
// No dependencies.
package spq_pkg;

  localparam int UNITS_PER_VOLT = 1536;
  localparam int MAX_NOTES      = 16;
  localparam int PAIRS          = MAX_NOTES - 1;
  localparam int NOTE_W         = 16;
  localparam int IDX_W          = $clog2(MAX_NOTES);

  localparam logic signed [17:0] Q_MIN = -18'sd16384;
  localparam logic signed [17:0] Q_MAX = 18'sd18431;

  // Opcodes of an input request.
  localparam logic [1:0] OP_SAMPLE    = 2'd0;
  localparam logic [1:0] OP_GATE_RISE = 2'd1;
  localparam logic [1:0] OP_GATE_FALL = 2'd2;

  // Configuration register indexes.
  localparam logic [2:0] REG_HOLD_MODE    = 3'd0;
  localparam logic [2:0] REG_NOTE_COUNT   = 3'd1;
  localparam logic [2:0] REG_NOTES_LOW    = 3'd2;
  localparam logic [2:0] REG_NOTES_SECOND = 3'd3;
  localparam logic [2:0] REG_NOTES_THIRD  = 3'd4;
  localparam logic [2:0] REG_NOTES_HIGH   = 3'd5;

  typedef logic [MAX_NOTES-1:0][NOTE_W-1:0] spq_notes_t;

  // Fields that ride along the whole pipeline.
  typedef struct packed {
    logic               ch;
    logic               vu;
    logic               gl;
    logic               gu;
    logic               pass;
    logic signed [14:0] v;
    logic signed [4:0]  oct;
  } spq_ctl_t;

  typedef struct packed {
    spq_ctl_t    ctl;
    logic [10:0] frac;
  } spq_s1_t;

  typedef struct packed {
    spq_ctl_t         ctl;
    logic [PAIRS-1:0] brk;
    logic [PAIRS-1:0] hi_sel;
    logic             top_up;
    logic [IDX_W-1:0] top_idx;
  } spq_s2_t;

  typedef struct packed {
    spq_ctl_t          ctl;
    logic [NOTE_W-1:0] base;
  } spq_s3_t;

endpackage

@@ hdl/spq_split.sv @@
// First pipeline stage: decodes the request and splits the voltage into
// octave and fraction. Depends on spq_pkg.
module spq_split (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  logic [1:0]         opcode,
  input  logic               channel,
  input  logic signed [14:0] input_voltage,
  input  logic               hold_mode,
  input  logic [4:0]         note_count,
  output logic               dn_valid,
  input  logic               dn_ready,
  output spq_pkg::spq_s1_t   dn_data
);
  import spq_pkg::*;

  logic               valid;
  spq_s1_t            data;
  spq_s1_t            data_next;
  logic               has_result;
  logic signed [5:0]  t;
  logic [6:0]         x;
  logic [14:0]        prod;
  logic signed [5:0]  oct6;
  logic signed [16:0] oct17;
  logic signed [16:0] rem;

  // floor(v / 1536) is floor(floor(v / 512) / 3); the divide by 3 of the
  // offset value (1..64) is a multiply by 171 / 512, exact over that range.
  always_comb begin
    t     = input_voltage[14:9];
    x     = 7'($signed({t[5], t}) + 7'sd33);
    prod  = 15'(x) * 15'd171;
    oct6  = $signed({1'b0, prod[13:9]}) - 6'sd11;
    oct17 = 17'(oct6);
    rem   = 17'(input_voltage) - (oct17 <<< 10) - (oct17 <<< 9);

    case (opcode)
      OP_SAMPLE:    has_result = !hold_mode;
      OP_GATE_RISE: has_result = hold_mode;
      OP_GATE_FALL: has_result = hold_mode;
      default:      has_result = 1'b0;
    endcase

    data_next.ctl.ch   = channel;
    data_next.ctl.vu   = (opcode == OP_SAMPLE) || (opcode == OP_GATE_RISE);
    data_next.ctl.gl   = (opcode == OP_GATE_RISE);
    data_next.ctl.gu   = (opcode == OP_GATE_RISE) || (opcode == OP_GATE_FALL);
    data_next.ctl.pass = (note_count == 5'd0);
    data_next.ctl.v    = input_voltage;
    data_next.ctl.oct  = oct6[4:0];
    data_next.frac     = rem[10:0];
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid && has_result;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

@@ hdl/spq_compare.sv @@
// Second pipeline stage: compares the fraction against every adjacent note
// pair and against the top note in parallel. Depends on spq_pkg.
module spq_compare (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  spq_pkg::spq_s1_t    up_data,
  input  logic [4:0]          note_count,
  input  spq_pkg::spq_notes_t notes,
  output logic                dn_valid,
  input  logic                dn_ready,
  output spq_pkg::spq_s2_t    dn_data
);
  import spq_pkg::*;

  logic               valid;
  spq_s2_t            data;
  spq_s2_t            data_next;
  logic [4:0]         n;
  logic [4:0]         top_n;
  logic [NOTE_W-1:0]  frac16;
  logic [NOTE_W-1:0]  d_hi [PAIRS];
  logic [NOTE_W-1:0]  d_lo [PAIRS];
  logic [NOTE_W-1:0]  top_note;
  logic signed [17:0] up_d;
  logic signed [17:0] low_d;

  always_comb begin
    n      = (note_count > 5'(MAX_NOTES)) ? 5'(MAX_NOTES) : note_count;
    top_n  = n - 5'd1;
    frac16 = NOTE_W'(up_data.frac);

    for (int i = 0; i < PAIRS; i++) begin
      d_hi[i] = notes[i+1] - frac16;
      d_lo[i] = frac16 - notes[i];
      data_next.brk[i] = (5'(i + 1) < n) && (frac16 >= notes[i]) &&
                         (frac16 <= notes[i+1]);
      // Only meaningful when the pair brackets the fraction.
      data_next.hi_sel[i] = d_hi[i] < d_lo[i];
    end

    top_note = notes[top_n[IDX_W-1:0]];
    up_d     = 18'(UNITS_PER_VOLT) - 18'(up_data.frac);
    low_d    = 18'(up_data.frac) - $signed({2'b00, top_note});

    data_next.ctl     = up_data.ctl;
    data_next.top_up  = up_d < low_d;
    data_next.top_idx = top_n[IDX_W-1:0];
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

@@ hdl/spq_select.sv @@
// Third pipeline stage: takes the first bracketing pair, or the top-note
// rule when none brackets, and picks the note. Depends on spq_pkg.
module spq_select (
  input  logic                clk,
  input  logic                rst,
  input  logic                up_valid,
  output logic                up_ready,
  input  spq_pkg::spq_s2_t    up_data,
  input  spq_pkg::spq_notes_t notes,
  output logic                dn_valid,
  input  logic                dn_ready,
  output spq_pkg::spq_s3_t    dn_data
);
  import spq_pkg::*;

  logic    valid;
  spq_s3_t data;
  spq_s3_t data_next;
  logic    found;

  always_comb begin
    found = 1'b0;
    // The next octave is the note just above the top one.
    if (up_data.top_up) begin
      data_next.base = NOTE_W'(UNITS_PER_VOLT);
    end else begin
      data_next.base = notes[up_data.top_idx];
    end
    for (int i = 0; i < PAIRS; i++) begin
      if (!found && up_data.brk[i]) begin
        found = 1'b1;
        data_next.base = up_data.hi_sel[i] ? notes[i+1] : notes[i];
      end
    end
    data_next.ctl = up_data.ctl;
  end

  assign up_ready = !valid || dn_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      data <= data_next;
    end
  end

  assign dn_valid = valid;
  assign dn_data  = data;

endmodule

@@ hdl/spq_output.sv @@
// Last pipeline stage and output register: adds the octave back, saturates
// and formats the result fields. Depends on spq_pkg.
module spq_output (
  input  logic               clk,
  input  logic               rst,
  input  logic               up_valid,
  output logic               up_ready,
  input  spq_pkg::spq_s3_t   up_data,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_channel,
  output logic signed [15:0] quantized_voltage,
  output logic               voltage_update,
  output logic               gate_level,
  output logic               gate_update
);
  import spq_pkg::*;

  logic               valid;
  logic signed [17:0] oct18;
  logic signed [17:0] sum;
  logic signed [17:0] sat;
  logic signed [15:0] q_next;

  always_comb begin
    oct18 = 18'(up_data.ctl.oct);
    if (up_data.ctl.pass) begin
      sum = 18'(up_data.ctl.v);
    end else begin
      sum = $signed({2'b00, up_data.base}) + (oct18 <<< 10) + (oct18 <<< 9);
    end
    if (sum < Q_MIN) begin
      sat = Q_MIN;
    end else if (sum > Q_MAX) begin
      sat = Q_MAX;
    end else begin
      sat = sum;
    end
    q_next = up_data.ctl.vu ? sat[15:0] : 16'sd0;
  end

  assign up_ready = !valid || !out_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (up_ready) begin
      valid <= up_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (up_ready) begin
      out_channel       <= up_data.ctl.ch;
      quantized_voltage <= q_next;
      voltage_update    <= up_data.ctl.vu;
      gate_level        <= up_data.ctl.gl;
      gate_update       <= up_data.ctl.gu;
    end
  end

  assign out_valid = valid;

  a_fall_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && !voltage_update |-> quantized_voltage == 16'sd0 && gate_update)
    else $error("gate-only result carries a voltage");

  a_tick_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && !gate_update |-> voltage_update && !gate_level)
    else $error("sample result has gate fields set");

  a_range: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> quantized_voltage >= -16'sd16384 && quantized_voltage <= 16'sd18431)
    else $error("quantized voltage outside the saturation range");

  a_level_rise: assert property (@(posedge clk) disable iff (rst)
    out_valid && gate_level |-> gate_update && voltage_update)
    else $error("gate high without a quantized voltage");

endmodule

@@ hdl/scale_pitch_quantizer.sv @@
// Top level of the two-channel scale pitch quantizer: configuration
// registers and the four-stage pipeline. Depends on spq_pkg and the spq_* stages.
//
//  channel   handshake              payload
//  -------   ---------------------  ---------------------------------------------
//  input     in_valid / in_stall    opcode, channel, input_voltage
//  output    out_valid / out_stall  out_channel, quantized_voltage, voltage_update,
//                                   gate_level, gate_update
//  config    cfg_write              cfg_index, cfg_data
//
// The accepting edge loads the first of four register stages: split into octave
// and fraction, parallel note compares, note pick, add and saturate into the
// output register. A new request is taken every cycle unless an output stall
// has backed up to the first stage. Requests that give no result are dropped
// in the first stage. Reset clears all configuration and the stage valid bits.
// A stall on the output backs up stage by stage, so the pipeline keeps up to
// four requests.
module scale_pitch_quantizer (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         opcode,
  input  logic               channel,
  input  logic signed [14:0] input_voltage,
  output logic               out_valid,
  input  logic               out_stall,
  output logic               out_channel,
  output logic signed [15:0] quantized_voltage,
  output logic               voltage_update,
  output logic               gate_level,
  output logic               gate_update,
  input  logic               cfg_write,
  input  logic [2:0]         cfg_index,
  input  logic [63:0]        cfg_data
);
  import spq_pkg::*;

  logic       hold_mode;
  logic [4:0] note_count;
  spq_notes_t notes;

  logic    s1_valid, s2_valid, s3_valid;
  logic    in_ready, s1_ready, s2_ready, s3_ready;
  spq_s1_t s1_data;
  spq_s2_t s2_data;
  spq_s3_t s3_data;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_mode  <= 1'b0;
      note_count <= 5'd0;
      notes      <= '0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_HOLD_MODE:    hold_mode     <= cfg_data[0];
        REG_NOTE_COUNT:   note_count    <= cfg_data[4:0];
        REG_NOTES_LOW:    notes[3:0]    <= cfg_data;
        REG_NOTES_SECOND: notes[7:4]    <= cfg_data;
        REG_NOTES_THIRD:  notes[11:8]   <= cfg_data;
        REG_NOTES_HIGH:   notes[15:12]  <= cfg_data;
        default: ;
      endcase
    end
  end

  spq_split u_split (
    .clk           (clk),
    .rst           (rst),
    .up_valid      (in_valid),
    .up_ready      (in_ready),
    .opcode        (opcode),
    .channel       (channel),
    .input_voltage (input_voltage),
    .hold_mode     (hold_mode),
    .note_count    (note_count),
    .dn_valid      (s1_valid),
    .dn_ready      (s1_ready),
    .dn_data       (s1_data)
  );

  spq_compare u_compare (
    .clk        (clk),
    .rst        (rst),
    .up_valid   (s1_valid),
    .up_ready   (s1_ready),
    .up_data    (s1_data),
    .note_count (note_count),
    .notes      (notes),
    .dn_valid   (s2_valid),
    .dn_ready   (s2_ready),
    .dn_data    (s2_data)
  );

  spq_select u_select (
    .clk      (clk),
    .rst      (rst),
    .up_valid (s2_valid),
    .up_ready (s2_ready),
    .up_data  (s2_data),
    .notes    (notes),
    .dn_valid (s3_valid),
    .dn_ready (s3_ready),
    .dn_data  (s3_data)
  );

  spq_output u_output (
    .clk               (clk),
    .rst               (rst),
    .up_valid          (s3_valid),
    .up_ready          (s3_ready),
    .up_data           (s3_data),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_channel       (out_channel),
    .quantized_voltage (quantized_voltage),
    .voltage_update    (voltage_update),
    .gate_level        (gate_level),
    .gate_update       (gate_update)
  );

  assign in_stall = !in_ready;

endmodule

@@ bench/tb.sv @@
`timescale 1ns / 100ps
// Self-checking bench for scale_pitch_quantizer: directed and random CV requests
// against an in-bench scale predictor, with random input gaps and output stalls.
// Depends on spq_pkg and the scale_pitch_quantizer RTL.
module tb;
  import spq_pkg::*;

  localparam int LIMIT = 400000;
  localparam int IDLE_PCT = 22;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;
  localparam int Q_LOW = -16384;
  localparam int Q_HIGH = 18431;

  typedef struct {
    logic [1:0]         op;
    logic               ch;
    logic signed [14:0] v;
  } cv_req_t;

  typedef struct {
    bit                 has;
    logic               ch;
    logic signed [15:0] q;
    logic               vu;
    logic               gl;
    logic               gu;
  } pitch_out_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [1:0]         opcode = OP_SAMPLE;
  logic               channel = 1'b0;
  logic signed [14:0] input_voltage = '0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic               out_channel;
  logic signed [15:0] quantized_voltage;
  logic               voltage_update;
  logic               gate_level;
  logic               gate_update;
  logic               cfg_write = 1'b0;
  logic [2:0]         cfg_index = REG_HOLD_MODE;
  logic [63:0]        cfg_data = '0;

  // Bench copy of the configuration.
  logic        hold_cfg = 1'b0;
  logic [4:0]  count_cfg = '0;
  logic [63:0] quad_cfg [4] = '{default: '0};

  cv_req_t    cv_requests[$];
  pitch_out_t quantized_due[$];

  bit calm = 1'b0;
  int fails = 0;
  int cycles = 0;
  int n_taken = 0;
  int n_samples = 0;
  int n_gates = 0;
  int n_checked = 0;
  int n_settings = 0;

  scale_pitch_quantizer dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall),
    .opcode(opcode), .channel(channel), .input_voltage(input_voltage),
    .out_valid(out_valid), .out_stall(out_stall),
    .out_channel(out_channel), .quantized_voltage(quantized_voltage),
    .voltage_update(voltage_update), .gate_level(gate_level),
    .gate_update(gate_update),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #4 clk = ~clk;

  function automatic int scale_note(int i);
    return int'(quad_cfg[i / 4][(i % 4) * 16 +: 16]);
  endfunction

  // Snaps a voltage to the nearest configured note, in its octave or the next one.
  function automatic logic signed [15:0] snap_to_scale(int v);
    int  n, oct, frac, lo, hi, top, q;
    bit  found;
    n = int'(count_cfg);
    found = 1'b0;
    q = v;
    if (n > MAX_NOTES) n = MAX_NOTES;
    if (n != 0) begin
      if (v >= 0) oct = v / UNITS_PER_VOLT;
      else oct = -((-v + UNITS_PER_VOLT - 1) / UNITS_PER_VOLT);
      frac = v - oct * UNITS_PER_VOLT;
      for (int i = 0; i + 1 < n; i++) begin
        lo = scale_note(i);
        hi = scale_note(i + 1);
        if (!found && frac >= lo && frac <= hi) begin
          found = 1'b1;
          q = (hi - frac < frac - lo) ? hi + oct * UNITS_PER_VOLT
                                      : lo + oct * UNITS_PER_VOLT;
        end
      end
      if (!found) begin
        // Nothing brackets the fraction: top note against the next octave.
        top = scale_note(n - 1);
        if (UNITS_PER_VOLT - frac < frac - top) q = (oct + 1) * UNITS_PER_VOLT;
        else q = top + oct * UNITS_PER_VOLT;
      end
    end
    if (q < Q_LOW) q = Q_LOW;
    if (q > Q_HIGH) q = Q_HIGH;
    return q[15:0];
  endfunction

  function automatic pitch_out_t pitch_response(cv_req_t r);
    pitch_out_t o;
    o = '{has: 1'b0, ch: r.ch, q: '0, vu: 1'b0, gl: 1'b0, gu: 1'b0};
    case (r.op)
      OP_SAMPLE: begin
        if (!hold_cfg) begin
          o.has = 1'b1;
          o.q = snap_to_scale(int'(r.v));
          o.vu = 1'b1;
        end
      end
      OP_GATE_RISE: begin
        if (hold_cfg) begin
          o.has = 1'b1;
          o.q = snap_to_scale(int'(r.v));
          o.vu = 1'b1;
          o.gl = 1'b1;
          o.gu = 1'b1;
        end
      end
      OP_GATE_FALL: begin
        if (hold_cfg) begin
          o.has = 1'b1;
          o.gu = 1'b1;
        end
      end
      default: ;
    endcase
    return o;
  endfunction

  // Request driver: a new request is presented only once the last one is taken.
  always @(posedge clk) begin : drive_cv
    cv_req_t    req;
    pitch_out_t due;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        req = '{op: opcode, ch: channel, v: input_voltage};
        n_taken++;
        if (opcode == OP_SAMPLE) n_samples++;
        else if (opcode != OP_UNUSED) n_gates++;
        due = pitch_response(req);
        if (due.has) quantized_due.push_back(due);
      end
      if (!in_valid || !in_stall) begin
        if (cv_requests.size() != 0 && (calm || $urandom_range(99) >= IDLE_PCT)) begin
          req = cv_requests.pop_front();
          in_valid <= 1'b1;
          opcode <= req.op;
          channel <= req.ch;
          input_voltage <= req.v;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // Result monitor and random output stall.
  always @(posedge clk) begin : check_out
    pitch_out_t want;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        if (quantized_due.size() == 0) begin
          fails++;
          if (fails <= 10)
            $display("tb: unexpected result ch=%0d q=%0d vu=%0d gl=%0d gu=%0d",
                     out_channel, quantized_voltage, voltage_update, gate_level,
                     gate_update);
        end else begin
          want = quantized_due.pop_front();
          n_checked++;
          if (out_channel !== want.ch || quantized_voltage !== want.q ||
              voltage_update !== want.vu || gate_level !== want.gl ||
              gate_update !== want.gu) begin
            fails++;
            if (fails <= 10)
              $display({"tb: mismatch exp ch=%0d q=%0d vu=%0d gl=%0d gu=%0d,",
                        " got ch=%0d q=%0d vu=%0d gl=%0d gu=%0d"},
                       want.ch, want.q, want.vu, want.gl, want.gu,
                       out_channel, quantized_voltage, voltage_update,
                       gate_level, gate_update);
          end
        end
      end
      out_stall <= !calm && ($urandom_range(99) < IDLE_PCT);
    end
  end

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: errors");
      $finish;
    end
  end

  task automatic cfg_put(logic [2:0] idx, logic [63:0] data);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    case (idx)
      REG_HOLD_MODE:    hold_cfg = data[0];
      REG_NOTE_COUNT:   count_cfg = data[4:0];
      REG_NOTES_LOW:    quad_cfg[0] = data;
      REG_NOTES_SECOND: quad_cfg[1] = data;
      REG_NOTES_THIRD:  quad_cfg[2] = data;
      REG_NOTES_HIGH:   quad_cfg[3] = data;
      default: ;
    endcase
    @(posedge clk);
    cfg_write <= 1'b0;
  endtask

  task automatic push_req(logic [1:0] op, logic ch, int v);
    cv_requests.push_back('{op: op, ch: ch, v: v[14:0]});
  endtask

  // Waits until every request is taken and every result has come back.
  task automatic drain();
    do @(posedge clk);
    while (cv_requests.size() != 0 || in_valid || quantized_due.size() != 0);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  initial begin : stimulus
    int counts [8] = '{16, 1, 0, 31, 7, 16, 2, 12};
    bit holds  [8] = '{0, 1, 0, 1, 1, 0, 1, 0};
    logic [15:0] notes [16];
    logic [63:0] packed_quad;
    int step, acc, r, v;
    logic [1:0] op;

    repeat (3) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset settings: continuous mode, no notes, so samples pass through.
    n_settings++;
    push_req(OP_SAMPLE, 1'b0, -16384);
    push_req(OP_SAMPLE, 1'b1, 16383);
    push_req(OP_SAMPLE, 1'b1, 0);
    push_req(OP_SAMPLE, 1'b0, -1);
    push_req(OP_GATE_RISE, 1'b0, 100);
    push_req(OP_GATE_FALL, 1'b1, 100);
    push_req(OP_UNUSED, 1'b0, 100);
    drain();

    // Three notes 256, 768, 1024: ties, below the first note, the top-note rule.
    n_settings++;
    cfg_put(REG_HOLD_MODE, 64'd0);
    cfg_put(REG_NOTE_COUNT, 64'd3);
    cfg_put(REG_NOTES_LOW, 64'h0000_0400_0300_0100);
    push_req(OP_SAMPLE, 1'b0, 100);
    push_req(OP_SAMPLE, 1'b1, 512);
    push_req(OP_SAMPLE, 1'b0, 513);
    push_req(OP_SAMPLE, 1'b1, 1280);
    push_req(OP_SAMPLE, 1'b0, 1300);
    push_req(OP_SAMPLE, 1'b1, -1);
    push_req(OP_SAMPLE, 1'b0, 16383);
    drain();

    // Hold mode, all sixteen notes, the last one far out of range to saturate.
    n_settings++;
    cfg_put(REG_HOLD_MODE, 64'd1);
    cfg_put(REG_NOTE_COUNT, 64'd16);
    cfg_put(REG_NOTES_SECOND, {$urandom, $urandom});
    cfg_put(REG_NOTES_THIRD, {$urandom, $urandom});
    cfg_put(REG_NOTES_HIGH, 64'hFFFF_0000_FFFF_0000);
    cfg_put(REG_SPARE_LO, {$urandom, $urandom});
    cfg_put(REG_SPARE_HI, {$urandom, $urandom});
    push_req(OP_GATE_RISE, 1'b0, 16383);
    push_req(OP_GATE_FALL, 1'b0, 16383);
    push_req(OP_SAMPLE, 1'b1, 700);
    push_req(OP_UNUSED, 1'b1, 700);
    push_req(OP_GATE_RISE, 1'b1, -16384);
    push_req(OP_GATE_RISE, 1'b1, 0);
    push_req(OP_GATE_FALL, 1'b1, 0);
    drain();

    for (int ph = 0; ph < 8; ph++) begin
      n_settings++;
      // Mostly ascending scales inside one octave; every third one is raw noise.
      acc = $urandom_range(0, 120);
      step = 1536 / (counts[ph] > 16 ? 17 : counts[ph] + 1);
      for (int i = 0; i < 16; i++) begin
        if (ph % 3 == 2) notes[i] = 16'($urandom);
        else begin
          notes[i] = acc[15:0];
          acc += $urandom_range(1, step);
        end
      end
      cfg_put(REG_HOLD_MODE, {$urandom, 31'($urandom), holds[ph]});
      cfg_put(REG_NOTE_COUNT, 64'(counts[ph]));
      for (int qd = 0; qd < 4; qd++) begin
        packed_quad = {notes[qd * 4 + 3], notes[qd * 4 + 2],
                       notes[qd * 4 + 1], notes[qd * 4]};
        cfg_put(REG_NOTES_LOW + 3'(qd), packed_quad);
      end
      calm = (ph == 4);
      for (int k = 0; k < 160; k++) begin
        r = $urandom_range(99);
        if (holds[ph]) op = (r < 45) ? OP_GATE_RISE : (r < 85) ? OP_GATE_FALL :
                            (r < 95) ? OP_SAMPLE : OP_UNUSED;
        else op = (r < 85) ? OP_SAMPLE : (r < 92) ? OP_GATE_RISE :
                  (r < 97) ? OP_GATE_FALL : OP_UNUSED;
        r = $urandom_range(9);
        if (r == 0) v = $urandom_range(0, 1) ? 16383 - $urandom_range(0, 1600)
                                              : -16384 + $urandom_range(0, 1600);
        else if (r == 1) v = $urandom_range(0, 3071) - 1536;
        else v = $urandom_range(0, 32767) - 16384;
        push_req(op, 1'($urandom_range(0, 1)), v);
      end
      drain();
      calm = 1'b0;
    end

    if (quantized_due.size() != 0) begin
      fails++;
      $display("tb: %0d results never arrived", quantized_due.size());
    end
    $display("tb: %0d requests taken (%0d samples, %0d gate edges)",
             n_taken, n_samples, n_gates);
    $display("tb: %0d results checked under %0d register settings",
             n_checked, n_settings);
    if (fails == 0) $display("tb: clean");
    else $display("tb: errors");
    $finish;
  end

endmodule
